FILE: hdl/cwpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwpc_pkg - shared types and constants of the confidence window chooser
// Beat formats, configuration register map, command codes and FSM states.
// ----------------------------------------------------------------------------
package cwpc_pkg;

    localparam int PC_W          = 64;
    localparam int LKP_W         = 10;   // width of lookup_index / update_index
    localparam int CNT_W         = 8;    // widest confidence counter
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;
    localparam int TABLE_ENTRIES_DEF = 1024;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STATES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INST_SHIFT    = 2'd2;

    // reset values of the registers
    localparam logic [3:0] RST_COUNTER_BITS  = 4'd2;
    localparam logic [8:0] RST_WINDOW_STATES = 9'd2;
    localparam logic [1:0] RST_INST_SHIFT    = 2'd2;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic             command;
        logic [PC_W-1:0]  pc;
        logic             simple_prediction;
        logic             complex_prediction;
        logic [LKP_W-1:0] update_index;
        logic             taken;
        logic             is_conditional;
        logic             squashed;
    } t_in_item;

    typedef struct packed {
        logic             prediction;
        logic             chose_complex;
        logic [LKP_W-1:0] lookup_index;
    } t_out_item;

endpackage

FILE: hdl/confidence_window_predictor_chooser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// confidence_window_predictor_chooser - chooser between two branch predictors
// Saturating confidence counters in one RAM pick the simple or the complex
// direction; updates train the counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter RAM to zero, one entry per cycle,
// and takes no input beat until all TABLE_ENTRIES entries (1024 by default)
// are clear; configuration writes are taken at any time. Afterwards the
// accept cycle of each beat issues the RAM read, the next cycle gets the
// registered read data, decides (lookup) or writes the adjusted counter back
// (update), and loads the result register. One item is in flight at a time,
// so a read never meets a pending write to the same entry. The result
// register holds a finished beat while the next input beat is accepted; a
// stalled result stretches the execute cycle until the register frees up.
// TABLE_ENTRIES must be a power of two; lookup_index carries the low index
// bits. Every input beat, lookup or update, yields exactly one result beat.
// ----------------------------------------------------------------------------
module confidence_window_predictor_chooser #(
    parameter int TABLE_ENTRIES = cwpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cwpc_pkg::t_in_item             i_in_data,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cwpc_pkg::t_out_item            o_out_data,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cwpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cwpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    // wide enough to hold both the update index and TABLE_ENTRIES itself
    localparam int CMP_W = (IDX_W >= cwpc_pkg::LKP_W) ? IDX_W + 1 : cwpc_pkg::LKP_W + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cwpc_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]    r_clr_addr;
    cwpc_pkg::t_in_item  r_item;
    logic [IDX_W-1:0]    r_addr;
    cwpc_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [3:0]          r_counter_bits;
    logic [8:0]          r_window_states;
    logic [1:0]          r_inst_shift;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_finish;
    logic [cwpc_pkg::PC_W-1:0]     w_pc_shift;
    logic [IDX_W-1:0]              w_in_idx;
    logic [3:0]                    w_bits;
    logic [8:0]                    w_span;
    logic [8:0]                    w_ws_eff;
    logic [8:0]                    w_lower;
    logic [8:0]                    w_upper;
    logic [cwpc_pkg::CNT_W-1:0]    w_maxv;
    logic [cwpc_pkg::CNT_W-1:0]    w_rdata;
    logic [cwpc_pkg::CNT_W-1:0]    w_clamped;
    logic [cwpc_pkg::CNT_W-1:0]    w_new_cnt;
    logic                          w_in_win;
    logic                          w_upd_ok;
    cwpc_pkg::t_out_item           w_result;
    logic                          w_ram_we;
    logic [IDX_W-1:0]              w_ram_waddr;
    logic [cwpc_pkg::CNT_W-1:0]    w_ram_wdata;
    logic [IDX_W-1:0]              w_ram_raddr;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == cwpc_pkg::ST_EXEC) && w_out_free;

    // table index of the incoming beat: shifted pc for a lookup, the
    // remembered index for an update
    assign w_pc_shift = i_in_data.pc >> r_inst_shift;
    assign w_in_idx   = (i_in_data.command == cwpc_pkg::CMD_LOOKUP)
                      ? w_pc_shift[IDX_W-1:0]
                      : IDX_W'(i_in_data.update_index);

    // ------------------------------------------------------------------
    // Window bounds and counter arithmetic
    // ------------------------------------------------------------------
    always_comb begin
        // clamp the counter width to 1..8
        if (r_counter_bits == 4'd0) begin
            w_bits = 4'd1;
        end else if (r_counter_bits > 4'(cwpc_pkg::CNT_W)) begin
            w_bits = 4'(cwpc_pkg::CNT_W);
        end else begin
            w_bits = r_counter_bits;
        end
        w_span = 9'd1 << w_bits;

        // window width: at least one state, at most the whole range
        w_ws_eff = (r_window_states == 9'd0) ? 9'd1 : r_window_states;
        if (w_ws_eff > w_span) begin
            w_ws_eff = w_span;
        end
        w_lower = (w_span - w_ws_eff + 9'd1) >> 1;
        w_upper = w_lower + w_ws_eff - 9'd1;
        w_maxv  = 8'(w_span - 9'd1);

        // lookups compare the counter as stored
        w_in_win = ({1'b0, w_rdata} >= w_lower) && ({1'b0, w_rdata} <= w_upper);

        // updates clamp to the current range, then count with saturation
        w_clamped = (w_rdata > w_maxv) ? w_maxv : w_rdata;
        if (r_item.taken) begin
            w_new_cnt = (w_clamped < w_maxv) ? w_clamped + 8'd1 : w_clamped;
        end else begin
            w_new_cnt = (w_clamped != 8'd0) ? w_clamped - 8'd1 : w_clamped;
        end

        w_upd_ok = (r_item.command == cwpc_pkg::CMD_UPDATE) && !r_item.squashed
                 && r_item.is_conditional
                 && (CMP_W'(r_item.update_index) < CMP_W'(TABLE_ENTRIES));

        // result beat
        if (r_item.command == cwpc_pkg::CMD_LOOKUP) begin
            w_result.prediction    = w_in_win ? r_item.complex_prediction
                                              : r_item.simple_prediction;
            w_result.chose_complex = w_in_win;
            w_result.lookup_index  = cwpc_pkg::LKP_W'(r_addr);
        end else begin
            w_result.prediction    = 1'b0;
            w_result.chose_complex = 1'b0;
            w_result.lookup_index  = r_item.update_index;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwpc_pkg::ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = cwpc_pkg::ST_IDLE;
                end
            end
            cwpc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = cwpc_pkg::ST_EXEC;
                end
            end
            cwpc_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    n_state = cwpc_pkg::ST_IDLE;
                end
            end
            default: n_state = cwpc_pkg::ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and RAM port control
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = w_new_cnt;
        w_ram_raddr = w_in_idx;
        unique case (r_state)
            cwpc_pkg::ST_CLEAR: begin
                // sweep the table to zero
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            cwpc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            cwpc_pkg::ST_EXEC: begin
                // hold the read address so stalled cycles keep valid data;
                // write back only once, on the cycle the beat retires
                w_ram_raddr = r_addr;
                w_ram_we    = w_finish && w_upd_ok;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Counter table
    // ------------------------------------------------------------------
    cwpc_ram #(
        .WIDTH (cwpc_pkg::CNT_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwpc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cwpc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers; out-of-map indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_bits  <= cwpc_pkg::RST_COUNTER_BITS;
            r_window_states <= cwpc_pkg::RST_WINDOW_STATES;
            r_inst_shift    <= cwpc_pkg::RST_INST_SHIFT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cwpc_pkg::CFG_COUNTER_BITS:  r_counter_bits  <= i_cfg_data[3:0];
                cwpc_pkg::CFG_WINDOW_STATES: r_window_states <= i_cfg_data[8:0];
                cwpc_pkg::CFG_INST_SHIFT:    r_inst_shift    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_addr <= w_in_idx;
        end
        if (w_finish) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: hdl/cwpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwpc_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cwpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cwpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwpc_checker - port-level assertions for the confidence window chooser
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module cwpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input cwpc_pkg::t_out_item             o_out_data
);

    // reset starts the table sweep: no input beat taken right after
    a_reset_blocks_input: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_in_ready
    ) else $error("input ready right after reset");

    // one item in flight: an accepted beat closes the input side next cycle
    a_one_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("second input beat taken while one is in flight");

    // a fresh result follows its input beat through the execute state and the result register
    a_result_latency: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2)
    ) else $error("result beat without a matching input beat");

    // a stalled result holds
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data))
    ) else $error("stalled result beat dropped or changed");

endmodule

bind confidence_window_predictor_chooser cwpc_checker u_cwpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
